>>> src/pise_pkg.sv
// ----------------------------------------------------------------------------
// Integer subset execute package
// Shared opcodes, status codes and control structures.
// ----------------------------------------------------------------------------
`default_nettype none
package pise_pkg;

  localparam logic [5:0] OP_BC   = 6'd16;
  localparam logic [5:0] OP_SC   = 6'd17;
  localparam logic [5:0] OP_B    = 6'd18;
  localparam logic [5:0] OP_BCLR = 6'd19;
  localparam logic [5:0] OP_ADDI = 6'd14;
  localparam logic [5:0] OP_ORI  = 6'd24;
  localparam logic [5:0] OP_XORI = 6'd26;
  localparam logic [5:0] OP_ANDI = 6'd28;
  localparam logic [5:0] OP_X    = 6'd31;

  localparam logic [9:0] XO_CMP   = 10'd0;
  localparam logic [9:0] XO_AND   = 10'd28;
  localparam logic [9:0] XO_XOR   = 10'd316;
  localparam logic [9:0] XO_OR    = 10'd444;
  localparam logic [9:0] XO_NAND  = 10'd476;
  localparam logic [9:0] XO_EXTSW = 10'd986;
  localparam logic [8:0] XO_ADD   = 9'd266;
  localparam logic [8:0] XO_SUBF  = 9'd40;
  localparam logic [8:0] XO_DIVW  = 9'd491;
  localparam logic [9:0] XO_BCLR0 = 10'd0;
  localparam logic [9:0] XO_BCLR1 = 10'd16;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNSUP = 2'd1;
  localparam logic [1:0] ST_SC    = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // latch instruction
    logic rd_req;    // register file read issue
    logic exec;      // execute and commit (non-divide)
    logic div_start; // start divider
    logic div_step;  // one divider iteration
    logic div_done;  // commit divide result
    logic out_load;  // load result register
  } pise_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_div;
    logic div_last;
  } pise_stat_t;

endpackage
`default_nettype wire

>>> src/pise_datapath.sv
// ----------------------------------------------------------------------------
// Integer subset execute datapath
// Register file memory, ALU, branch unit and a radix-2 word divider.
// ----------------------------------------------------------------------------
`default_nettype none
module pise_datapath #(
  parameter int NumRegs = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [31:0]        instruction_i,
  input  wire pise_pkg::pise_cmd_t cmd_i,
  output pise_pkg::pise_stat_t    stat_o,
  output logic                    write_enable_o,
  output logic [4:0]              write_index_o,
  output logic [63:0]             write_value_o,
  output logic [3:0]              condition_field_o,
  output logic [63:0]             next_address_o,
  output logic [1:0]              status_o
);
  localparam int IdxW = $clog2(NumRegs);

  // Architectural state.
  logic [63:0] gpr_mem [NumRegs];
  logic [NumRegs-1:0] gpr_vld_q;
  logic [63:0] cia_q, lr_q, srr_q;
  logic [31:0] cr_q;
  logic [31:0] ir_q;

  logic [63:0] rt_q, ra_q, rb_q;
  logic rt_v_q, ra_v_q, rb_v_q;

  // Instruction fields.
  logic [5:0] op;
  logic [4:0] ft, fa, fb;
  logic [9:0] xo10;
  logic [8:0] xo9;
  logic aa, lk;
  assign op = ir_q[31:26];
  assign ft = ir_q[25:21];
  assign fa = ir_q[20:16];
  assign fb = ir_q[15:11];
  assign xo10 = ir_q[10:1];
  assign xo9 = ir_q[9:1];
  assign aa = ir_q[1];
  assign lk = ir_q[0];

  logic [63:0] rt, ra, rb, imm, nia4;
  assign rt = rt_v_q ? rt_q : 64'd0;
  assign ra = ra_v_q ? ra_q : 64'd0;
  assign rb = rb_v_q ? rb_q : 64'd0;
  assign imm = {{48{ir_q[15]}}, ir_q[15:0]};
  assign nia4 = cia_q + 64'd4;

  // Divider state: restoring division on magnitudes, one bit per step.
  logic [31:0] dq_q, dr_q, dd_q;
  logic [5:0] dcnt_q;
  logic dneg_q, dzero_q;
  logic [32:0] dtrial;
  assign dtrial = {dr_q, dq_q[31]} - {1'b0, dd_q};

  logic is_div;
  assign is_div = (op == pise_pkg::OP_X) && (xo9 == pise_pkg::XO_DIVW) &&
                  !(xo10 == pise_pkg::XO_AND || xo10 == pise_pkg::XO_NAND ||
                    xo10 == pise_pkg::XO_OR || xo10 == pise_pkg::XO_XOR ||
                    xo10 == pise_pkg::XO_EXTSW || xo10 == pise_pkg::XO_CMP);
  assign stat_o.is_div = is_div;
  assign stat_o.div_last = (dcnt_q == 6'd31);

  // Execute logic.
  logic we;
  logic [4:0] widx;
  logic [63:0] wval, nia, lr_d, srr_d;
  logic [31:0] cr_d;
  logic [1:0] st;
  logic [3:0] fcmp;
  logic [63:0] boff, bcoff;
  logic take;
  always_comb begin
    we = 1'b0;
    widx = 5'd0;
    wval = 64'd0;
    nia = nia4;
    lr_d = lr_q;
    srr_d = srr_q;
    cr_d = cr_q;
    st = pise_pkg::ST_OK;
    boff = {{38{ir_q[25]}}, ir_q[25:2], 2'b00};
    bcoff = {{48{ir_q[15]}}, ir_q[15:2], 2'b00};
    take = ft[4] || (cr_q[5'd31 - fa] == ft[3]);
    if ($signed(ra) < $signed(rb)) fcmp = 4'b1000;
    else if ($signed(ra) > $signed(rb)) fcmp = 4'b0100;
    else fcmp = 4'b0010;
    case (op)
      pise_pkg::OP_X: begin
        if (xo10 == pise_pkg::XO_AND) begin
          we = 1'b1; widx = fa; wval = rt & rb;
        end else if (xo10 == pise_pkg::XO_NAND) begin
          we = 1'b1; widx = fa; wval = ~(rt & rb);
        end else if (xo10 == pise_pkg::XO_OR) begin
          we = 1'b1; widx = fa; wval = rt | rb;
        end else if (xo10 == pise_pkg::XO_XOR) begin
          we = 1'b1; widx = fa; wval = rt ^ rb;
        end else if (xo10 == pise_pkg::XO_EXTSW) begin
          we = 1'b1; widx = fa; wval = {{32{rt[31]}}, rt[31:0]};
        end else if (xo10 == pise_pkg::XO_CMP) begin
          cr_d = {fcmp, cr_q[27:0]};
        end else if (xo9 == pise_pkg::XO_ADD) begin
          we = 1'b1; widx = ft; wval = ra + rb;
        end else if (xo9 == pise_pkg::XO_SUBF) begin
          we = 1'b1; widx = ft; wval = rb - ra;
        end else if (xo9 == pise_pkg::XO_DIVW) begin
          we = 1'b1; widx = ft;
          wval = dzero_q ? 64'd0 :
                 {{32{1'b0}}, (dneg_q ? (32'd0 - dq_q) : dq_q)};
          wval[63:32] = {32{wval[31]}};
        end else begin
          st = pise_pkg::ST_UNSUP;
        end
      end
      pise_pkg::OP_ADDI: begin
        we = 1'b1; widx = ft; wval = ((fa == 5'd0) ? 64'd0 : ra) + imm;
      end
      pise_pkg::OP_ANDI: begin
        we = 1'b1; widx = ft; wval = ra & imm;
      end
      pise_pkg::OP_ORI: begin
        we = 1'b1; widx = ft; wval = ra | imm;
      end
      pise_pkg::OP_XORI: begin
        we = 1'b1; widx = ft; wval = ra ^ imm;
      end
      pise_pkg::OP_B: begin
        nia = aa ? boff : cia_q + boff;
        if (lk) lr_d = nia4;
      end
      pise_pkg::OP_BC: begin
        if (take) nia = aa ? bcoff : cia_q + bcoff;
        if (lk) lr_d = nia4;
      end
      pise_pkg::OP_BCLR: begin
        if (xo10 == pise_pkg::XO_BCLR0 || xo10 == pise_pkg::XO_BCLR1) begin
          nia = {lr_q[63:2], 2'b00};
          if (lk) lr_d = nia4;
        end else begin
          st = pise_pkg::ST_UNSUP;
        end
      end
      pise_pkg::OP_SC: begin
        srr_d = nia4; nia = 64'd0; st = pise_pkg::ST_SC;
      end
      default: st = pise_pkg::ST_UNSUP;
    endcase
  end

  // Register file: one write port, three registered reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_req) begin
      rt_q <= gpr_mem[ft[IdxW-1:0]];
      ra_q <= gpr_mem[fa[IdxW-1:0]];
      rb_q <= gpr_mem[fb[IdxW-1:0]];
    end
    if ((cmd_i.exec || cmd_i.div_done) && we) gpr_mem[widx[IdxW-1:0]] <= wval;
  end

  // Valid bits give reset value zero for unwritten registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpr_vld_q <= '0;
      rt_v_q <= 1'b0;
      ra_v_q <= 1'b0;
      rb_v_q <= 1'b0;
      cia_q <= 64'd0;
      lr_q <= 64'd0;
      srr_q <= 64'd0;
      cr_q <= 32'd0;
    end else begin
      if (cmd_i.rd_req) begin
        rt_v_q <= gpr_vld_q[ft[IdxW-1:0]];
        ra_v_q <= gpr_vld_q[fa[IdxW-1:0]];
        rb_v_q <= gpr_vld_q[fb[IdxW-1:0]];
      end
      if (cmd_i.exec || cmd_i.div_done) begin
        if (we) gpr_vld_q[widx[IdxW-1:0]] <= 1'b1;
        cia_q <= nia;
        lr_q <= lr_d;
        srr_q <= srr_d;
        cr_q <= cr_d;
      end
    end
  end

  // Instruction latch, divider and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) ir_q <= instruction_i;
    if (cmd_i.div_start) begin
      dq_q <= ra[31] ? (32'd0 - ra[31:0]) : ra[31:0];
      dd_q <= rb[31] ? (32'd0 - rb[31:0]) : rb[31:0];
      dr_q <= 32'd0;
      dcnt_q <= 6'd0;
      dneg_q <= ra[31] ^ rb[31];
      dzero_q <= (rb[31:0] == 32'd0) ||
                 (ra[31:0] == 32'h8000_0000 && rb[31:0] == 32'hFFFF_FFFF);
    end else if (cmd_i.div_step) begin
      if (!dtrial[32]) begin
        dr_q <= dtrial[31:0];
        dq_q <= {dq_q[30:0], 1'b1};
      end else begin
        dr_q <= {dr_q[30:0], dq_q[31]};
        dq_q <= {dq_q[30:0], 1'b0};
      end
      dcnt_q <= dcnt_q + 6'd1;
    end
    if (cmd_i.out_load) begin
      write_enable_o <= we;
      write_index_o <= we ? widx : 5'd0;
      write_value_o <= we ? wval : 64'd0;
      condition_field_o <= cr_d[31:28];
      next_address_o <= nia;
      status_o <= st;
    end
  end
endmodule
`default_nettype wire

>>> src/pise_control.sv
// ----------------------------------------------------------------------------
// Integer subset execute controller
// Sequences read, execute, divide and result handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module pise_control (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire pise_pkg::pise_stat_t stat_i,
  output pise_pkg::pise_cmd_t       cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DSTART, S_DIV, S_DONE
  } state_e;

  state_e state_q;
  logic out_valid_q;
  logic accept;

  // A new request enters only when idle and the result slot is free.
  assign in_stall_o = !(state_q == S_IDLE && !out_valid_q);
  assign accept = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = accept;
    cmd_o.rd_req = (state_q == S_READ);
    cmd_o.exec = (state_q == S_EXEC) && !stat_i.is_div;
    cmd_o.out_load = cmd_o.exec || (state_q == S_DONE);
    cmd_o.div_start = (state_q == S_DSTART);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.div_done = (state_q == S_DONE);
  end

  // State and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (accept) state_q <= S_READ;
        S_READ: state_q <= S_EXEC;
        S_EXEC: begin
          if (stat_i.is_div) begin
            state_q <= S_DSTART;
          end else begin
            state_q <= S_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        S_DSTART: state_q <= S_DIV;
        S_DIV: if (stat_i.div_last) state_q <= S_DONE;
        S_DONE: begin
          state_q <= S_IDLE;
          out_valid_q <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> src/power_integer_subset_execute.sv
// ----------------------------------------------------------------------------
// Power integer subset execute
// Executes one instruction word per request and reports its effects.
// ----------------------------------------------------------------------------
// Sequence: latch the instruction, read the register file, then execute
// and load the result; divw runs the 32-step divider before it commits.
// A new request is taken only when idle with the last result handed off.
// Reset: asynchronous, active low; all registers read as zero after reset.
`default_nettype none
module power_integer_subset_execute #(
  parameter int NumRegs = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] instruction_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             write_enable_o,
  output logic [4:0]       write_index_o,
  output logic [63:0]      write_value_o,
  output logic [3:0]       condition_field_o,
  output logic [63:0]      next_address_o,
  output logic [1:0]       status_o
);
  pise_pkg::pise_cmd_t cmd;
  pise_pkg::pise_stat_t stat;

  // Sequencer.
  pise_control u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  // Datapath.
  pise_datapath #(.NumRegs(NumRegs)) u_dp (
    .clk_i, .rst_ni, .instruction_i, .cmd_i(cmd), .stat_o(stat),
    .write_enable_o, .write_index_o, .write_value_o, .condition_field_o,
    .next_address_o, .status_o
  );
endmodule
`default_nettype wire

>>> src/pise_checker.sv
// ----------------------------------------------------------------------------
// Integer subset execute checker
// Port-level properties of the request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none
module pise_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        write_enable_o,
  input wire logic [1:0]  status_o
);
  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped under stall");
  // An accepted request blocks the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");
  // A register write is only reported with the executed status.
  a_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o |-> status_o == 2'd0)
    else $error("write with non-executed status");
  // Status code range.
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("bad status");
endmodule

bind power_integer_subset_execute pise_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .write_enable_o, .status_o
);
`default_nettype wire
